/* rtl/core/erast_pkg.sv */
// shared constants, types and helpers for the ellipse rasterizer core
package erast_pkg;

  localparam int COORD_BITS = 12;
  localparam int CENTER_W   = 12;
  localparam int AXIS_W     = 11;
  localparam int SQ_W       = 2 * AXIS_W;
  localparam int OUT_W      = 14;
  localparam int DEC_W      = 48;
  localparam int T_W        = 52;
  localparam int MUL_B_W    = (COORD_BITS + 1 > AXIS_W) ? COORD_BITS + 1 : AXIS_W;
  localparam int PROD_W     = SQ_W + MUL_B_W;
  localparam int WIDE_W     = COORD_BITS + OUT_W;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQA,
    ST_SQB,
    ST_AB,
    ST_D0,
    ST_D1,
    ST_PT,
    ST_T0,
    ST_T1,
    ST_XM,
    ST_XA,
    ST_XB,
    ST_YM,
    ST_YA,
    ST_YB,
    ST_EMIT
  } state_t;

  typedef struct packed {
    state_t st;
    logic   in_ready;
    logic   out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic opcode;
    logic active;
    logic t_mv_x;
    logic mv_y;
    logic out_free;
  } stat_t;

  // center plus or minus offset, wrapped to the output width
  function automatic logic [OUT_W-1:0] out_coord(input coord_t c, input coord_t o,
                                                 input logic sub);
    logic [WIDE_W-1:0] cw;
    logic [WIDE_W-1:0] ow;
    logic [WIDE_W-1:0] rw;
    cw = WIDE_W'(c);
    ow = WIDE_W'(o);
    rw = sub ? (cw - ow) : (cw + ow);
    return rw[OUT_W-1:0];
  endfunction

endpackage

/* rtl/core/ellipse_rasterizer_core.sv */
// ellipse rasterizer top level: one quadrant by decision variable, mirrored four ways
// sequence: start word runs SQA, SQB, AB, D0, D1, EMIT; step word runs PT, T0, T1, then
// XM/XA/XB, YM/YA/YB or both (diagonal), then EMIT; an idle-block step goes to EMIT
// throughput: one word in flight; in_ready returns the cycle after the result is loaded
// the micro-sequence is shaped by the single shared multiplier and single 52-bit adder
// reset: synchronous active-high rst clears state, offsets, centers and out_valid
module ellipse_rasterizer_core
  import erast_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    opcode,
  input  logic [CENTER_W-1:0]     center_x,
  input  logic [CENTER_W-1:0]     center_y,
  input  logic [AXIS_W-1:0]       semi_axis_x,
  input  logic [AXIS_W-1:0]       semi_axis_y,
  input  logic                    plot_enable,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] x_right,
  output logic signed [OUT_W-1:0] x_left,
  output logic signed [OUT_W-1:0] y_below,
  output logic signed [OUT_W-1:0] y_above,
  output logic                    plotted,
  output logic                    last
);

  ctrl_t ctrl;
  stat_t stat;

  // running ellipse state
  coord_t                   offset_x;
  coord_t                   offset_y;
  coord_t                   saved_center_x;
  coord_t                   saved_center_y;
  logic signed [DEC_W-1:0]  decision;
  logic [SQ_W-1:0]          axis_x_squared;
  logic [SQ_W-1:0]          axis_y_squared;
  logic                     drawing_active;
  logic                     plot_flag;

  // working registers for the micro-sequence
  logic [AXIS_W-1:0]        axis_a;
  logic [AXIS_W-1:0]        axis_b;
  logic signed [T_W-1:0]    t_val;
  logic                     dec_le0;
  logic                     mv_y;
  logic                     idle_emit;

  logic                     in_fire;
  logic                     start_fire;
  logic                     dec_le0_c;
  logic [COORD_BITS:0]      x_inc;
  coord_t                   y_dec;

  // shared multiplier
  logic                     mul_en;
  logic [SQ_W-1:0]          mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        prod;

  // shared adder
  logic signed [T_W-1:0]    dec_ext;
  logic signed [T_W-1:0]    prod2;
  logic signed [T_W-1:0]    a_ext;
  logic signed [T_W-1:0]    b_ext;
  logic signed [T_W-1:0]    opa;
  logic signed [T_W-1:0]    opb;
  logic signed [T_W-1:0]    sum;
  logic                     t_pos;
  logic                     t_neg;
  logic                     mv_x_c;
  logic                     mv_y_c;

  assign in_ready   = ctrl.in_ready;
  assign in_fire    = in_valid && ctrl.in_ready;
  assign start_fire = in_fire && (opcode == OP_START);

  // d <= 0 picks the horizontal-leaning branch
  assign dec_le0_c = decision[DEC_W-1] || (decision == '0);
  assign x_inc     = {1'b0, offset_x} + (COORD_BITS + 1)'(1);
  assign y_dec     = offset_y - COORD_BITS'(1);

  assign stat.in_valid = in_valid;
  assign stat.opcode   = opcode;
  assign stat.active   = drawing_active;
  assign stat.t_mv_x   = mv_x_c;
  assign stat.mv_y     = mv_y;
  assign stat.out_free = !out_valid || out_ready;

  erast_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // multiplier operand select: squares and A*b on start, A*y / B*x on steps
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (ctrl.st)
      ST_SQA: begin
        mul_a = SQ_W'(axis_a);
        mul_b = MUL_B_W'(axis_a);
      end
      ST_SQB: begin
        mul_a = SQ_W'(axis_b);
        mul_b = MUL_B_W'(axis_b);
      end
      ST_AB: begin
        mul_a = axis_x_squared;
        mul_b = MUL_B_W'(axis_b);
      end
      ST_PT: begin
        // old coordinates feed the test term
        mul_a = dec_le0_c ? axis_x_squared : axis_y_squared;
        mul_b = dec_le0_c ? MUL_B_W'(offset_y) : MUL_B_W'(offset_x);
      end
      ST_XM: begin
        // x+1 kept one bit wider so the product sees the unwrapped value
        mul_a = axis_y_squared;
        mul_b = MUL_B_W'(x_inc);
      end
      ST_YM: begin
        mul_a = axis_x_squared;
        mul_b = MUL_B_W'(y_dec);
      end
      default: mul_en = 1'b0;
    endcase
  end

  erast_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign dec_ext = {{(T_W - DEC_W){decision[DEC_W-1]}}, decision};
  assign prod2   = T_W'({prod, 1'b0});
  assign a_ext   = T_W'(axis_x_squared);
  assign b_ext   = T_W'(axis_y_squared);

  // adder operand select
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (ctrl.st)
      ST_D0: begin
        opa = a_ext;
        opb = b_ext;
      end
      ST_D1: begin
        opa = dec_ext;
        opb = -prod2;
      end
      ST_T0: begin
        opa = {dec_ext[T_W-2:0], 1'b0};
        opb = dec_le0 ? prod2 : -prod2;
      end
      ST_T1: begin
        opa = t_val;
        opb = dec_le0 ? -a_ext : -b_ext;
      end
      ST_XA: begin
        opa = dec_ext;
        opb = prod2;
      end
      ST_XB: begin
        opa = dec_ext;
        opb = b_ext;
      end
      ST_YA: begin
        opa = dec_ext;
        opb = -prod2;
      end
      ST_YB: begin
        opa = dec_ext;
        opb = a_ext;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign sum   = opa + opb;
  assign t_pos = !sum[T_W-1] && (sum != '0);
  assign t_neg = sum[T_W-1];

  // move choice: d <= 0 always steps x, diagonal when t > 0;
  // d > 0 always steps y, diagonal when t < 0
  assign mv_x_c = dec_le0 ? 1'b1 : t_neg;
  assign mv_y_c = dec_le0 ? t_pos : 1'b1;

  // visible state: offsets, centers, flags
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x       <= '0;
      offset_y       <= '0;
      saved_center_x <= '0;
      saved_center_y <= '0;
      drawing_active <= 1'b0;
      plot_flag      <= 1'b0;
    end else begin
      if (start_fire) begin
        saved_center_x <= COORD_BITS'(center_x);
        saved_center_y <= COORD_BITS'(center_y);
        plot_flag      <= plot_enable;
        offset_x       <= '0;
        offset_y       <= COORD_BITS'(semi_axis_y);
        // zero vertical semi-axis: the first point is already the last
        drawing_active <= (COORD_BITS'(semi_axis_y) != '0);
      end
      if (ctrl.st == ST_XM) begin
        offset_x <= x_inc[COORD_BITS-1:0];
      end
      if (ctrl.st == ST_YM) begin
        offset_y <= y_dec;
        if (y_dec == '0) begin
          drawing_active <= 1'b0;
        end
      end
    end
  end

  // working registers, loaded before use
  always_ff @(posedge clk) begin
    if (start_fire) begin
      axis_a <= semi_axis_x;
      axis_b <= semi_axis_y;
    end
    if (in_fire) begin
      // step word with no ellipse in progress repeats the held point
      idle_emit <= (opcode == OP_STEP) && !drawing_active;
    end
    if (ctrl.st == ST_SQB) begin
      axis_x_squared <= prod[SQ_W-1:0];
    end
    if (ctrl.st == ST_AB) begin
      axis_y_squared <= prod[SQ_W-1:0];
    end
    if (ctrl.st == ST_PT) begin
      dec_le0 <= dec_le0_c;
    end
    if (ctrl.st == ST_T0) begin
      t_val <= sum;
    end
    if (ctrl.st == ST_T1) begin
      mv_y <= mv_y_c;
    end
    if (ctrl.st == ST_D0 || ctrl.st == ST_D1 || ctrl.st == ST_XA ||
        ctrl.st == ST_XB || ctrl.st == ST_YA || ctrl.st == ST_YB) begin
      decision <= sum[DEC_W-1:0];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      x_right <= $signed(out_coord(saved_center_x, offset_x, 1'b0));
      x_left  <= $signed(out_coord(saved_center_x, offset_x, 1'b1));
      y_below <= $signed(out_coord(saved_center_y, offset_y, 1'b0));
      y_above <= $signed(out_coord(saved_center_y, offset_y, 1'b1));
      plotted <= plot_flag && !idle_emit;
      last    <= idle_emit || (offset_y == '0);
    end
  end

  // an ellipse in progress never sits on the x axis
  a_active_y: assert property (@(posedge clk) disable iff (rst)
    drawing_active |-> (offset_y != '0))
    else $error("active ellipse with zero y offset");

  // an accepted word always occupies the sequencer, so in_ready is low in the next cycle
  a_fire_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted back to back");

  // a result load always shows up on the output
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |=> out_valid)
    else $error("loaded word not presented");

  // step arithmetic only runs on a live ellipse
  a_step_live: assert property (@(posedge clk) disable iff (rst)
    (ctrl.st == ST_PT) |-> drawing_active)
    else $error("step sequence on idle block");

endmodule

/* rtl/core/erast_mul.sv */
// shared registered multiplier for squares and axis products
module erast_mul
  import erast_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [SQ_W-1:0]    op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op_a * op_b;
    end
  end

endmodule

/* rtl/core/erast_ctrl.sv */
// sequencer for the start and step micro-operations
module erast_ctrl
  import erast_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (stat.in_valid) begin
          if (stat.opcode == OP_START) begin
            state_next = ST_SQA;
          end else if (stat.active) begin
            state_next = ST_PT;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SQA:  state_next = ST_SQB;
      ST_SQB:  state_next = ST_AB;
      ST_AB:   state_next = ST_D0;
      ST_D0:   state_next = ST_D1;
      ST_D1:   state_next = ST_EMIT;
      ST_PT:   state_next = ST_T0;
      ST_T0:   state_next = ST_T1;
      ST_T1:   state_next = stat.t_mv_x ? ST_XM : ST_YM;
      ST_XM:   state_next = ST_XA;
      ST_XA:   state_next = ST_XB;
      ST_XB:   state_next = stat.mv_y ? ST_YM : ST_EMIT;
      ST_YM:   state_next = ST_YA;
      ST_YA:   state_next = ST_YB;
      ST_YB:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    ctrl.st       = state;
    ctrl.in_ready = (state == ST_IDLE);
    ctrl.out_load = (state == ST_EMIT) && stat.out_free;
  end

endmodule

/* tb/sv/ellipse_rasterizer_core_test.sv */
// self-checking testbench for ellipse_rasterizer_core: random handshake idling, predicted points
module ellipse_rasterizer_core_test;
  import erast_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int CALM_TAIL = 150;

  typedef struct packed {
    logic                op;
    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    logic [AXIS_W-1:0]   ax;
    logic [AXIS_W-1:0]   ay;
    logic                pe;
  } word_t;

  typedef struct packed {
    logic [OUT_W-1:0] xr;
    logic [OUT_W-1:0] xl;
    logic [OUT_W-1:0] yb;
    logic [OUT_W-1:0] ya;
    logic             plot;
    logic             fin;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  word_t cur_word = '0;
  logic signed [OUT_W-1:0] x_right, x_left, y_below, y_above;
  logic plotted, last;

  word_t  pending_words[$];
  point_t expected_points[$];
  int     mismatches = 0;
  int     points_seen = 0;
  int     in_gap = 0;
  int     out_stall = 0;
  int     quiet_cycles = 0;

  // predictor state
  coord_t                   pos_x = '0, pos_y = '0;
  logic signed [DEC_W-1:0]  err = '0;
  logic [SQ_W-1:0]          sq_a = '0, sq_b = '0;
  coord_t                   org_x = '0, org_y = '0;
  logic                     tracing = 1'b0;
  logic                     draw_flag = 1'b0;

  ellipse_rasterizer_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(cur_word.op), .center_x(cur_word.cx), .center_y(cur_word.cy),
    .semi_axis_x(cur_word.ax), .semi_axis_y(cur_word.ay), .plot_enable(cur_word.pe),
    .out_valid(out_valid), .out_ready(out_ready),
    .x_right(x_right), .x_left(x_left), .y_below(y_below), .y_above(y_above),
    .plotted(plotted), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // four mirrored coordinates of the held offset, wrapped to the output width
  function automatic point_t held_point(logic plot, logic fin);
    point_t p;
    p.xr = OUT_W'(org_x) + OUT_W'(pos_x);
    p.xl = OUT_W'(org_x) - OUT_W'(pos_x);
    p.yb = OUT_W'(org_y) + OUT_W'(pos_y);
    p.ya = OUT_W'(org_y) - OUT_W'(pos_y);
    p.plot = plot;
    p.fin = fin;
    return p;
  endfunction

  // start loads a new ellipse, step moves one pixel (idle step repeats the held point)
  function automatic point_t rasterize_word(word_t w);
    longint a, b, sa, sb, x, y, d, t;
    if (w.op == OP_START) begin
      a = longint'(w.ax);
      b = longint'(w.ay);
      org_x = w.cx;
      org_y = w.cy;
      draw_flag = w.pe;
      sq_a = SQ_W'(a * a);
      sq_b = SQ_W'(b * b);
      sa = longint'(sq_a);
      sb = longint'(sq_b);
      d = sb - 2 * sa * b + sa;
      err = d[DEC_W-1:0];
      pos_x = '0;
      pos_y = b[COORD_BITS-1:0];
      tracing = (pos_y != '0);
      return held_point(draw_flag, pos_y == '0);
    end
    // idle step repeats the held point, never drawn
    if (!tracing) return held_point(1'b0, 1'b1);
    sa = longint'(sq_a);
    sb = longint'(sq_b);
    x = longint'(pos_x);
    y = longint'(pos_y);
    d = longint'(err);
    if (d <= 0) begin
      t = 2 * d + 2 * sa * y - sa;
      x = x + 1;
      if (t <= 0) begin
        d = d + 2 * sb * x + sb;
      end else begin
        y = y - 1;
        d = d + 2 * sb * x - 2 * sa * y + sa + sb;
      end
    end else begin
      t = 2 * d - 2 * sb * x - sb;
      y = y - 1;
      if (t >= 0) begin
        d = d - 2 * sa * y + sa;
      end else begin
        x = x + 1;
        d = d + 2 * sb * x - 2 * sa * y + sa + sb;
      end
    end
    pos_x = x[COORD_BITS-1:0];
    pos_y = y[COORD_BITS-1:0];
    err = d[DEC_W-1:0];
    if (pos_y == '0) tracing = 1'b0;
    return held_point(draw_flag, pos_y == '0);
  endfunction

  task automatic queue_word(logic op, logic [CENTER_W-1:0] cx, logic [CENTER_W-1:0] cy,
                            logic [AXIS_W-1:0] ax, logic [AXIS_W-1:0] ay, logic pe);
    word_t w;
    w.op = op;
    w.cx = cx;
    w.cy = cy;
    w.ax = ax;
    w.ay = ay;
    w.pe = pe;
    pending_words.push_back(w);
  endtask

  // step words carry random don't-care payload
  task automatic queue_steps(int n);
    for (int i = 0; i < n; i++) begin
      queue_word(OP_STEP, CENTER_W'($urandom_range(0, 4095)),
                 CENTER_W'($urandom_range(0, 4095)),
                 AXIS_W'($urandom_range(0, 2047)), AXIS_W'($urandom_range(0, 2047)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on point %0d: %s got 0x%0h want 0x%0h", points_seen, what, got, want);
    mismatches++;
  endtask

  // idling comes in stretches keyed off progress, and stops near the end
  function automatic bit idle_roll();
    if (pending_words.size() < CALM_TAIL) return 1'b0;
    if ((pending_words.size() / 100) % 3 == 0) return 1'b0;
    return $urandom_range(0, 3) == 0;
  endfunction

  // driver
  always @(posedge clk) begin : drive
    word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) expected_points.push_back(rasterize_word(cur_word));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_roll()) begin
          in_gap <= $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else begin
          w = pending_words.pop_front();
          cur_word <= w;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    point_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected word", longint'(x_right), longint'(0));
        end else begin
          want = expected_points.pop_front();
          if (x_right !== want.xr)
            report_mismatch("x_right", longint'(x_right), longint'(want.xr));
          if (x_left !== want.xl)
            report_mismatch("x_left", longint'(x_left), longint'(want.xl));
          if (y_below !== want.yb)
            report_mismatch("y_below", longint'(y_below), longint'(want.yb));
          if (y_above !== want.ya)
            report_mismatch("y_above", longint'(y_above), longint'(want.ya));
          if (plotted !== want.plot)
            report_mismatch("plotted", longint'(plotted), longint'(want.plot));
          if (last !== want.fin)
            report_mismatch("last", longint'(last), longint'(want.fin));
        end
        points_seen++;
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else if (idle_roll()) begin
        out_stall <= $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ellipse_rasterizer_core_test: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int pick, ax, ay, span;
    bit big;
    // step on an idle block right after reset
    queue_word(OP_STEP, '1, '1, '1, '1, 1'b1);
    // widest ellipse at the far corner, abandoned by a new start
    queue_word(OP_START, 12'd4095, 12'd4095, 11'd2047, 11'd2047, 1'b1);
    queue_steps(4);
    // zero horizontal axis: vertical line, then an idle step
    queue_word(OP_START, 12'd0, 12'd0, 11'd0, 11'd3, 1'b1);
    queue_steps(4);
    // zero vertical axis: first point is already the last
    queue_word(OP_START, 12'd100, 12'd200, 11'd5, 11'd0, 1'b0);
    queue_steps(1);
    queue_word(OP_START, 12'd4095, 12'd0, 11'd1, 11'd1, 1'b1);
    queue_steps(3);
    queue_word(OP_START, 12'd0, 12'd4095, 11'd6, 11'd2, 1'b0);
    queue_steps(7);

    while (pending_words.size() < 1375) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_word(1'($urandom_range(0, 1)), CENTER_W'($urandom_range(0, 4095)),
                   CENTER_W'($urandom_range(0, 4095)),
                   AXIS_W'($urandom_range(0, 2047)), AXIS_W'($urandom_range(0, 2047)),
                   1'($urandom_range(0, 1)));
      end else begin
        big = ($urandom_range(0, 19) == 0);
        ax = big ? $urandom_range(0, 2047) : $urandom_range(0, 12);
        ay = big ? $urandom_range(0, 2047) : $urandom_range(0, 12);
        queue_word(OP_START, CENTER_W'($urandom_range(0, 4095)),
                   CENTER_W'($urandom_range(0, 4095)),
                   AXIS_W'(ax), AXIS_W'(ay), 1'($urandom_range(0, 1)));
        span = ax + ay + $urandom_range(0, 3);
        if (big) span = $urandom_range(5, 40);
        else if ($urandom_range(0, 7) == 0) span = $urandom_range(0, span);
        queue_steps(span);
      end
    end

    while (pending_words.size() != 0 || in_valid || expected_points.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("ellipse_rasterizer_core_test: done, clean");
    end else begin
      $display("ellipse_rasterizer_core_test: done, errors");
    end
    $finish;
  end

endmodule
